// ===== rtl/modexp_pkg.sv =====
// Shared constants, types and command/status structs for the modular exponentiation core.
package modexp_pkg;

  // Field widths of the item ports.
  localparam int BASE_W   = 32;
  localparam int EXP_W    = 32;
  localparam int POW_W    = 30;

  // Number of exponent bits that take part in the scan.
  localparam int EXP_BITS = 32;

  // The prime modulus, its Barrett constant and the datapath widths that follow.
  localparam logic [63:0] PRIME_64 = 64'd1000000007;
  localparam logic [POW_W-1:0] PRIME = PRIME_64[POW_W-1:0];
  localparam int X_W      = 2 * POW_W;       // full product width
  localparam int Q_W      = POW_W + 1;       // quotient estimate width
  localparam int R_W      = POW_W + 2;       // remainder before correction, below 3P
  localparam int MUL_W    = 32;              // shared multiplier operand width
  localparam logic [63:0] MU_64 = (64'd1 << X_W) / PRIME_64;
  localparam logic [Q_W-1:0] BARRETT_MU = MU_64[Q_W-1:0];

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;      // capture a new item, start base reduction
    logic mul;       // form a full product into x_r
    logic mul_sqr;   // product is run*run instead of acc*run
    logic qest;      // Barrett quotient estimate
    logic qsub;      // remainder = x - q*P
    logic fix;       // one conditional subtract of P
    logic wb_acc;    // final correction, write accumulator
    logic wb_run;    // final correction, write running power
    logic shift;     // drop the lowest exponent bit
    logic out_load;  // load the result register
  } modexp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic exp_zero;  // no exponent bits left
    logic exp_lsb;   // current exponent bit
    logic exp_last;  // current bit is the highest one set
  } modexp_sts_t;

endpackage

// ===== rtl/modular_exponentiation_core.sv =====
// Top level of the modular exponentiation core: controller plus datapath.
// Computes base^exponent mod 1000000007 by right-to-left square-and-multiply on one
// shared 32x32 multiplier with Barrett reduction; one item is in work at a time.
// For each item the base is loaded and reduced first; then, per exponent bit up to
// the highest set bit, the running power is squared, after a multiply into the
// accumulator where the bit is set; the highest set bit takes the multiply only,
// and the result is then handed over. A zero exponent skips the bit steps. Each
// modular product runs through product, quotient estimate, remainder and two
// corrections. The next item is taken as soon as the result sits in the output
// register, even if that result has not been transferred yet.
module modular_exponentiation_core (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [modexp_pkg::BASE_W-1:0]  in_base,
  input  logic [modexp_pkg::EXP_W-1:0]   in_exponent,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [modexp_pkg::POW_W-1:0]   out_power_mod
);
  import modexp_pkg::*;

  modexp_cmd_t cmd;
  modexp_sts_t sts;

  modexp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  modexp_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_base       (in_base),
    .in_exponent   (in_exponent),
    .cmd           (cmd),
    .sts           (sts),
    .out_power_mod (out_power_mod)
  );

endmodule

// ===== rtl/modexp_dp.sv =====
// Datapath: operand registers, shared multiplier and Barrett reduction steps.
module modexp_dp (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic [modexp_pkg::BASE_W-1:0]  in_base,
  input  logic [modexp_pkg::EXP_W-1:0]   in_exponent,
  input  modexp_pkg::modexp_cmd_t        cmd,
  output modexp_pkg::modexp_sts_t        sts,
  output logic [modexp_pkg::POW_W-1:0]   out_power_mod
);
  import modexp_pkg::*;

  logic [EXP_BITS-1:0] exp_r;
  logic [POW_W-1:0]    acc_r;
  logic [POW_W-1:0]    run_r;
  logic [X_W-1:0]      x_r;
  logic [Q_W-1:0]      q_r;
  logic [R_W-1:0]      r_r;
  logic [POW_W-1:0]    out_power_mod_r;

  logic [MUL_W-1:0]    mul_a;
  logic [MUL_W-1:0]    mul_b;
  logic [2*MUL_W-1:0]  prod;
  logic [R_W-1:0]      r_fixed;

  // Operand selection for the one shared multiplier.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (cmd.mul) begin
      mul_a = MUL_W'(cmd.mul_sqr ? run_r : acc_r);
      mul_b = MUL_W'(run_r);
    end else if (cmd.qest) begin
      mul_a = MUL_W'(x_r[X_W-1:POW_W-1]);
      mul_b = MUL_W'(BARRETT_MU);
    end else begin
      mul_a = MUL_W'(q_r);
      mul_b = MUL_W'(PRIME);
    end
  end

  assign prod = (2*MUL_W)'(mul_a) * (2*MUL_W)'(mul_b);

  // One conditional subtract of the modulus.
  assign r_fixed = (r_r >= R_W'(PRIME)) ? r_r - R_W'(PRIME) : r_r;

  // Operand, product and remainder registers.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      exp_r <= EXP_BITS'(in_exponent);
      acc_r <= POW_W'(1);
      x_r   <= X_W'(in_base);
    end
    if (cmd.mul) begin
      x_r <= prod[X_W-1:0];
    end
    if (cmd.qest) begin
      q_r <= prod[X_W+1:POW_W+1];
    end
    if (cmd.qsub) begin
      r_r <= x_r[R_W-1:0] - prod[R_W-1:0];
    end
    if (cmd.fix) begin
      r_r <= r_fixed;
    end
    if (cmd.wb_acc) begin
      acc_r <= r_fixed[POW_W-1:0];
    end
    if (cmd.wb_run) begin
      run_r <= r_fixed[POW_W-1:0];
    end
    if (cmd.shift) begin
      exp_r <= exp_r >> 1;
    end
    if (!rst_n) begin
      out_power_mod_r <= '0;
    end else if (cmd.out_load) begin
      out_power_mod_r <= acc_r;
    end
  end

  // Exponent status for the scan.
  assign sts.exp_zero = (exp_r == '0);
  assign sts.exp_lsb  = exp_r[0];
  assign sts.exp_last = ((exp_r >> 1) == '0);

  assign out_power_mod = out_power_mod_r;

`ifndef SYNTHESIS
  // Written operands are fully reduced.
  a_acc_reduced: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.wb_acc |=> acc_r < PRIME) else $error("accumulator not reduced");
  a_run_reduced: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.wb_run |=> run_r < PRIME) else $error("running power not reduced");
  // After one correction the Barrett remainder is below twice the modulus.
  a_fix_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.fix |=> r_r < R_W'(2 * PRIME_64)) else $error("remainder out of range");
`endif

endmodule

// ===== rtl/modexp_ctrl.sv =====
// Controller: sequences base reduction, square-and-multiply steps and result transfer.
module modexp_ctrl (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  output logic                     out_valid,
  input  logic                     out_ready,
  input  modexp_pkg::modexp_sts_t  sts,
  output modexp_pkg::modexp_cmd_t  cmd
);
  import modexp_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_MUL  = 8'b0000_0010,
    S_QEST = 8'b0000_0100,
    S_QSUB = 8'b0000_1000,
    S_FIX  = 8'b0001_0000,
    S_WB   = 8'b0010_0000,
    S_NEXT = 8'b0100_0000,
    S_DONE = 8'b1000_0000
  } state_t;

  // Which register a modular product goes back to.
  typedef enum logic [1:0] {
    DST_BASE = 2'd0,
    DST_ACC  = 2'd1,
    DST_SQR  = 2'd2
  } dest_t;

  state_t state_r, state_nxt;
  dest_t  dest_r, dest_nxt;
  logic   out_valid_r, out_valid_nxt;

  // Next-state and command decode.
  always_comb begin
    state_nxt = state_r;
    dest_nxt  = dest_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          dest_nxt  = DST_BASE;
          state_nxt = S_QEST;
        end
      end
      S_MUL: begin
        cmd.mul     = 1'b1;
        cmd.mul_sqr = (dest_r == DST_SQR);
        state_nxt   = S_QEST;
      end
      S_QEST: begin
        cmd.qest  = 1'b1;
        state_nxt = S_QSUB;
      end
      S_QSUB: begin
        cmd.qsub  = 1'b1;
        state_nxt = S_FIX;
      end
      S_FIX: begin
        cmd.fix   = 1'b1;
        state_nxt = S_WB;
      end
      S_WB: begin
        case (dest_r)
          DST_ACC: begin
            cmd.wb_acc = 1'b1;
            if (sts.exp_last) begin
              state_nxt = S_DONE;
            end else begin
              dest_nxt  = DST_SQR;
              state_nxt = S_MUL;
            end
          end
          DST_SQR: begin
            cmd.wb_run = 1'b1;
            cmd.shift  = 1'b1;
            state_nxt  = S_NEXT;
          end
          default: begin
            cmd.wb_run = 1'b1;
            state_nxt  = S_NEXT;
          end
        endcase
      end
      S_NEXT: begin
        if (sts.exp_zero) begin
          state_nxt = S_DONE;
        end else if (sts.exp_lsb) begin
          dest_nxt  = DST_ACC;
          state_nxt = S_MUL;
        end else begin
          dest_nxt  = DST_SQR;
          state_nxt = S_MUL;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Result valid holds until its transfer completes.
  assign out_valid_nxt = (out_valid_r && !out_ready) || cmd.out_load;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      dest_r      <= DST_BASE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      dest_r      <= dest_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

`ifndef SYNTHESIS
  // A new result is loaded only into a free output register.
  a_out_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_valid_r || out_ready)) else $error("result overwritten");
  // The block is busy right after an input transfer.
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready) else $error("accepted while busy");
  // A finished item waits while the previous result is stalled.
  a_done_wait: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && out_valid_r && !out_ready) |=> state_r == S_DONE)
    else $error("left done state while output stalled");
`endif

endmodule

// ===== dv/testbench.sv =====
// Self-checking testbench for the modular exponentiation core with a power-mod scoreboard.
module testbench;

  import modexp_pkg::*;

  localparam int N_RANDOM     = 1100;
  localparam int CYCLE_LIMIT  = 2500000;
  localparam int DRAIN_CYCLES = 40;
  localparam int REPORT_MAX   = 10;

  // Scoreboard that predicts base^exponent mod the prime and checks each result in order.
  class power_scoreboard;
    logic [POW_W-1:0] expected_powers[$];
    int               mismatches;

    function new();
      mismatches = 0;
    endfunction

    // Right-to-left square-and-multiply over the active exponent bits.
    function logic [POW_W-1:0] raise_mod_prime(logic [BASE_W-1:0] base,
                                               logic [EXP_W-1:0] exponent);
      logic [63:0] acc;
      logic [63:0] run;
      acc = 64'd1;
      run = {32'd0, base} % PRIME_64;
      for (int i = 0; i < EXP_BITS && i < EXP_W; i++) begin
        if (exponent[i]) begin
          acc = (acc * run) % PRIME_64;
        end
        run = (run * run) % PRIME_64;
      end
      return acc[POW_W-1:0];
    endfunction

    // An accepted input transfer yields exactly one expected power.
    function void note_operands(logic [BASE_W-1:0] base, logic [EXP_W-1:0] exponent);
      expected_powers.push_back(raise_mod_prime(base, exponent));
    endfunction

    // Compare one accepted result against the oldest expected power.
    function void check_power(logic [POW_W-1:0] power_mod);
      logic [POW_W-1:0] want;
      if (expected_powers.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_MAX) begin
          $display("ERROR: unexpected result power_mod=%0d", power_mod);
        end
      end else begin
        want = expected_powers.pop_front();
        if (power_mod !== want) begin
          mismatches++;
          if (mismatches <= REPORT_MAX) begin
            $display("ERROR: power_mod expected %0d, got %0d", want, power_mod);
          end
        end
      end
    endfunction

    function int pending();
      return expected_powers.size();
    endfunction

    function int failures();
      return mismatches + expected_powers.size();
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [BASE_W-1:0]   in_base = '0;
  logic [EXP_W-1:0]    in_exponent = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [POW_W-1:0]    out_power_mod;

  power_scoreboard     sb = new();
  int                  cycle_count = 0;
  int                  stall_mode = 0;
  int                  stall_left = 0;

  modular_exponentiation_core i_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_base       (in_base),
    .in_exponent   (in_exponent),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_power_mod (out_power_mod)
  );

  always #6 clk = ~clk;

  // Watchdog on the total run length.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Result side: check each transfer, then pick the next ready value from the stall pattern.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      sb.check_power(out_power_mod);
    end
    if (stall_left == 0) begin
      stall_mode <= $urandom_range(0, 3);
      stall_left <= $urandom_range(20, 300);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= ($urandom_range(0, 1) == 1);
      2: out_ready <= (stall_left % 40) < 5;
      default: out_ready <= ($urandom_range(0, 7) != 0);
    endcase
  end

  // Present one operand pair and hold it until the core accepts it.
  task automatic send_operands(logic [BASE_W-1:0] base, logic [EXP_W-1:0] exponent);
    in_valid    <= 1'b1;
    in_base     <= base;
    in_exponent <= exponent;
    do @(posedge clk); while (!in_ready);
    sb.note_operands(base, exponent);
  endtask

  // Random base, weighted toward multiples of the prime, values around it, small values and values near the top.
  function automatic logic [BASE_W-1:0] pick_base();
    case ($urandom_range(0, 9))
      5: return PRIME_64[31:0] * $urandom_range(0, 4);
      6: return PRIME_64[31:0] + $urandom_range(0, 4) - 2;
      7: return $urandom_range(0, 15);
      8: return 32'hFFFF_FFFF - $urandom_range(0, 15);
      default: return $urandom;
    endcase
  endfunction

  // Random exponent, often full width, with short, zero, single-bit, all-ones and small values mixed in.
  function automatic logic [EXP_W-1:0] pick_exponent();
    logic [EXP_W-1:0] mask;
    case ($urandom_range(0, 9))
      4, 5, 6: begin
        mask = (32'd1 << $urandom_range(1, 31)) - 1;
        return $urandom & mask;
      end
      7: return '0;
      8: return 32'd1 << $urandom_range(0, 31);
      9: return ($urandom_range(0, 1) == 1) ? 32'hFFFF_FFFF : $urandom_range(0, 3);
      default: return $urandom;
    endcase
  endfunction

  initial begin
    logic [BASE_W-1:0] base;
    logic [EXP_W-1:0]  exponent;
    int                burst_left;
    int                gap;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: zero exponent, multiples of the prime, field extremes, single bits and alternating patterns.
    send_operands(32'd0, 32'd0);
    send_operands(PRIME_64[31:0], 32'd0);
    send_operands(32'hFFFF_FFFF, 32'd0);
    send_operands(32'd0, 32'd1);
    send_operands(32'd0, 32'hFFFF_FFFF);
    send_operands(PRIME_64[31:0], 32'd5);
    send_operands(PRIME_64[31:0] * 2, 32'd3);
    send_operands(PRIME_64[31:0] * 4, 32'hFFFF_FFFF);
    send_operands(PRIME_64[31:0] - 1, 32'd2);
    send_operands(PRIME_64[31:0] - 1, 32'hFFFF_FFFF);
    send_operands(PRIME_64[31:0] + 1, 32'h1234_5678);
    send_operands(32'hFFFF_FFFF, 32'd1);
    send_operands(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_operands(32'd1, 32'hFFFF_FFFF);
    send_operands(32'd2, 32'd31);
    send_operands(32'd2, 32'h8000_0000);
    send_operands(32'd3, 32'h8000_0001);
    send_operands(32'hAAAA_AAAA, 32'h5555_5555);
    send_operands(32'h5555_5555, 32'hAAAA_AAAA);
    send_operands(32'd12345, 32'd1);

    // Random operand pairs sent in bursts separated by idle gaps.
    burst_left = $urandom_range(1, 16);
    for (int i = 0; i < N_RANDOM; i++) begin
      base     = pick_base();
      exponent = pick_exponent();
      send_operands(base, exponent);
      burst_left--;
      if (i == N_RANDOM / 2) begin
        // Let the core drain completely before going on.
        in_valid <= 1'b0;
        do @(posedge clk); while (sb.pending() != 0);
      end else if (burst_left <= 0) begin
        burst_left = $urandom_range(1, 16);
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        if (gap > 0) begin
          in_valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
    end

    // Wait for every outstanding result, then watch for strays.
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (sb.failures() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
